// ----- rtl/core/mtflru_pkg.sv -----
// package for the move-to-front recency list
// types, constants and control structs shared by all rtl/core modules
`default_nettype none

package mtflru_pkg;

  localparam int DepthDefault = 16;
  localparam int KeyW         = 31;

  // request codes
  localparam logic ReqAccess = 1'b0;
  localparam logic ReqDump   = 1'b1;

  typedef struct packed {
    logic            req_type;
    logic [KeyW-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [KeyW-1:0] item_value;
    logic            item_valid;
    logic            last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic do_access;
    logic do_rotate;
    logic load_entry;
    logic load_term;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic front_used;
  } dp_status_t;

endpackage : mtflru_pkg

`default_nettype wire

// ----- rtl/core/mtflru_dp.sv -----
// datapath: slot registers, parallel search and shift, output payload
// depends on mtflru_pkg
`default_nettype none

module mtflru_dp
  import mtflru_pkg::*;
#(
  parameter int DEPTH = DepthDefault
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire dp_cmd_t         cmd,
  input  wire logic [KeyW-1:0] key,
  output dp_status_t           status,
  output out_item_t            out_item
);

  logic [KeyW-1:0] slot_key_r   [DEPTH];
  logic [KeyW-1:0] slot_key_nxt [DEPTH];
  logic [DEPTH-1:0] slot_used_r;
  logic [DEPTH-1:0] slot_used_nxt;
  logic [DEPTH-1:0] cont;
  logic [DEPTH-1:0] shift_en;
  out_item_t        out_item_r;
  out_item_t        out_item_nxt;

  // a slot lets the search pass when it is used and does not match
  always_comb begin
    for (int m = 0; m < DEPTH; m++) begin
      cont[m] = slot_used_r[m] && (slot_key_r[m] != key);
    end
  end

  // slot j takes slot j-1 when every slot ahead of it let the search pass
  always_comb begin
    logic [DEPTH-1:0] ahead;
    for (int j = 0; j < DEPTH; j++) begin
      for (int m = 0; m < DEPTH; m++) begin
        ahead[m] = (m < j);
      end
      shift_en[j] = &(cont | ~ahead);
    end
  end

  // next slot contents: access shifts and inserts, rotate walks the list
  always_comb begin
    for (int j = 0; j < DEPTH; j++) begin
      slot_key_nxt[j]  = slot_key_r[j];
      slot_used_nxt[j] = slot_used_r[j];
    end
    if (cmd.do_access) begin
      slot_key_nxt[0]  = key;
      slot_used_nxt[0] = 1'b1;
      for (int j = 1; j < DEPTH; j++) begin
        if (shift_en[j]) begin
          slot_key_nxt[j]  = slot_key_r[j-1];
          slot_used_nxt[j] = slot_used_r[j-1];
        end
      end
    end else if (cmd.do_rotate) begin
      for (int j = 0; j < DEPTH; j++) begin
        slot_key_nxt[j]  = slot_key_r[(j == DEPTH-1) ? 0 : j+1];
        slot_used_nxt[j] = slot_used_r[(j == DEPTH-1) ? 0 : j+1];
      end
    end
  end

  // output payload
  always_comb begin
    out_item_nxt = out_item_r;
    if (cmd.load_entry) begin
      out_item_nxt.item_value = slot_key_r[0];
      out_item_nxt.item_valid = 1'b1;
      out_item_nxt.last       = 1'b0;
    end else if (cmd.load_term) begin
      out_item_nxt.item_value = '0;
      out_item_nxt.item_valid = 1'b0;
      out_item_nxt.last       = 1'b1;
    end
  end

  // used bits are control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_used_r <= '0;
    end else begin
      slot_used_r <= slot_used_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    for (int j = 0; j < DEPTH; j++) begin
      slot_key_r[j] <= slot_key_nxt[j];
    end
    out_item_r <= out_item_nxt;
  end

  assign status.front_used = slot_used_r[0];
  assign out_item          = out_item_r;

endmodule : mtflru_dp

`default_nettype wire

// ----- rtl/core/mtflru_ctrl.sv -----
// controller: request decode, dump sequencing, output valid
// depends on mtflru_pkg
`default_nettype none

module mtflru_ctrl
  import mtflru_pkg::*;
#(
  parameter int DEPTH = DepthDefault
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_req_type,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  localparam int CntW = $clog2(DEPTH + 1);

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_t;

  state_t          state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;
  logic            in_fire;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_req_type == ReqDump) begin
            state_nxt = ST_DUMP;
            cnt_nxt   = '0;
          end else begin
            cmd.do_access = 1'b1;
          end
        end
      end
      ST_DUMP: begin
        // one rotation per step; after a full turn the list is back in place
        if (out_free) begin
          if (cnt_r == CntW'(DEPTH)) begin
            cmd.load_term = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            cmd.do_rotate = 1'b1;
            cnt_nxt       = cnt_r + 1'b1;
            if (status.front_used) begin
              cmd.load_entry = 1'b1;
              out_valid_nxt  = 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule : mtflru_ctrl

`default_nettype wire

// ----- rtl/core/move_to_front_lru_list_top.sv -----
// move-to-front recency list: access moves a key to the front, dump emits the list
// access: a new item each cycle while no dump is in progress; no result
// dump: one rotation step per slot, then the terminator, each step held while the
//   output is stalled; the key of each used slot is emitted as an entry, then the
//   terminator (the only result for an empty list)
// reset (synchronous, rst_n low): list empty, controller idle, no result pending
`default_nettype none

module move_to_front_lru_list_top
  import mtflru_pkg::*;
#(
  parameter int DEPTH = DepthDefault
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  mtflru_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_req_type(in_data.req_type),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .cmd        (cmd)
  );

  mtflru_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .key     (in_data.key),
    .status  (status),
    .out_item(out_data)
  );

endmodule : move_to_front_lru_list_top

`default_nettype wire
